// ===== rtl/core/lfa_pkg.sv =====
// Shared types, sizes and status codes of the FIFO lock arbiter.
package lfa_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OPC_REQUEST = 2'd0;
  localparam logic [1:0] OPC_FORCE   = 2'd1;
  localparam logic [1:0] OPC_RELEASE = 2'd2;

  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_NOT_ADMIN  = 3'd2;
  localparam logic [2:0] ST_OVERRIDE   = 3'd3;
  localparam logic [2:0] ST_NOT_HOLDER = 3'd4;
  localparam logic [2:0] ST_RELEASED   = 3'd5;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd6;

  typedef enum logic [2:0] {
    CMD_REQUEST,
    CMD_FORCE,
    CMD_DENY,
    CMD_RELEASE,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ID_BITS-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       grant_valid;
    logic [7:0] grant_id;
    logic       holder_valid;
    logic [7:0] holder_id;
    logic [4:0] queue_length;
  } res_t;

endpackage

// ===== rtl/core/lfa_front.sv =====
// Front end: decodes incoming commands and buffers them in a two-entry queue.
module lfa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    requester_i,
  input  logic          is_admin_i,
  output logic          cmd_valid_o,
  output lfa_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import lfa_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       wr_en, rd_en;

  // Classify: fold the admin check of a takeover into the command kind.
  always_comb begin
    cmd_in.id = requester_i[ID_BITS-1:0];
    case (opcode_i)
      OPC_REQUEST: cmd_in.kind = CMD_REQUEST;
      OPC_FORCE:   cmd_in.kind = is_admin_i ? CMD_FORCE : CMD_DENY;
      OPC_RELEASE: cmd_in.kind = CMD_RELEASE;
      default:     cmd_in.kind = CMD_NOP;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/core/lfa_exec.sv =====
// Back end: lock state, shift-register wait queue and command execution.
module lfa_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  lfa_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output lfa_pkg::res_t res_o
);
  import lfa_pkg::*;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_PUSH_FRONT,
    ACT_POP_FRONT
  } act_e;

  logic [ID_BITS-1:0] q_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0] q_d [QUEUE_DEPTH];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               held_q, held_d;
  logic [ID_BITS-1:0] holder_q, holder_d;

  logic [QUEUE_DEPTH-1:0] hit_id_vec, hit_holder_vec;
  logic                   hit_id, hit_holder, q_full, fire, gv, push_holder;
  logic [ID_BITS-1:0]     gid;
  logic [2:0]             status;
  act_e                   act;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_take_o = fire;
  assign res_push_o = fire;

  // Parallel membership compare over the valid part of the queue.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_id_vec[i]     = (CNT_W'(i) < count_q) && (q_q[i] == cmd_i.id);
      hit_holder_vec[i] = (CNT_W'(i) < count_q) && (q_q[i] == holder_q);
    end
  end

  assign hit_id      = |hit_id_vec;
  assign hit_holder  = |hit_holder_vec;
  assign q_full      = (count_q >= CNT_W'(QUEUE_DEPTH));
  assign push_holder = held_q && !hit_holder;

  always_comb begin
    act      = ACT_NONE;
    count_d  = count_q;
    held_d   = held_q;
    holder_d = holder_q;
    gv       = 1'b0;
    gid      = '0;
    status   = ST_NOT_HOLDER;
    case (cmd_i.kind)
      CMD_REQUEST: begin
        if (!held_q) begin
          held_d   = 1'b1;
          holder_d = cmd_i.id;
          gv       = 1'b1;
          gid      = cmd_i.id;
          status   = ST_GRANTED;
        end else if (hit_id) begin
          status = ST_QUEUED;
        end else if (q_full) begin
          status = ST_QUEUE_FULL;
        end else begin
          act     = ACT_APPEND;
          count_d = count_q + 1'b1;
          status  = ST_QUEUED;
        end
      end
      CMD_FORCE: begin
        if (push_holder && q_full) begin
          status = ST_QUEUE_FULL;
        end else begin
          if (push_holder) begin
            act     = ACT_PUSH_FRONT;
            count_d = count_q + 1'b1;
          end
          held_d   = 1'b1;
          holder_d = cmd_i.id;
          gv       = 1'b1;
          gid      = cmd_i.id;
          status   = ST_OVERRIDE;
        end
      end
      CMD_DENY: status = ST_NOT_ADMIN;
      CMD_RELEASE: begin
        if (held_q && (holder_q == cmd_i.id)) begin
          if (count_q != '0) begin
            act      = ACT_POP_FRONT;
            count_d  = count_q - 1'b1;
            holder_d = q_q[0];
            gv       = 1'b1;
            gid      = q_q[0];
          end else begin
            held_d   = 1'b0;
            holder_d = '0;
          end
          status = ST_RELEASED;
        end
      end
      default: status = ST_NOT_HOLDER;
    endcase
  end

  // Next queue contents: append at the tail, shift in at the head, or advance.
  always_comb begin
    q_d = q_q;
    case (act)
      ACT_APPEND: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (CNT_W'(i) == count_q) q_d[i] = cmd_i.id;
        end
      end
      ACT_PUSH_FRONT: begin
        q_d[0] = holder_q;
        for (int i = 1; i < QUEUE_DEPTH; i++) q_d[i] = q_q[i-1];
      end
      ACT_POP_FRONT: begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_d[i] = q_q[i+1];
      end
      default: q_d = q_q;
    endcase
  end

  always_comb begin
    res_o.status       = status;
    res_o.grant_valid  = gv;
    res_o.grant_id     = 8'(gid);
    res_o.holder_valid = held_d;
    res_o.holder_id    = held_d ? 8'(holder_d) : 8'd0;
    res_o.queue_length = 5'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (fire) q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      held_q   <= 1'b0;
      holder_q <= '0;
    end else if (fire) begin
      count_q  <= count_d;
      held_q   <= held_d;
      holder_q <= holder_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("wait queue count beyond depth");

  a_free_holder_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (holder_q == '0))
    else $error("holder not cleared while lock is free");

  a_grant_is_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.grant_valid |-> res_o.holder_valid && (res_o.holder_id == res_o.grant_id))
    else $error("granted client is not the holder");

  a_deny_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (cmd_i.kind == CMD_DENY) |=> $stable(count_q) && $stable(holder_q)
      && $stable(held_q))
    else $error("refused takeover changed the lock state");

endmodule

// ===== rtl/core/lfa_resq.sv =====
// Result queue: two-entry buffer between execution and the result port.
module lfa_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  input  lfa_pkg::res_t res_i,
  output logic          res_full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lfa_pkg::res_t res_o
);
  import lfa_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign res_o      = mem_q[rd_ptr_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/core/fifo_lock_arbiter_with_preemption_unit.sv =====
// Two-entry queues on both sides: a command waits in the front queue and is executed once the
// result queue has room; its result is registered there. Throughput: one transaction per cycle
// while the result queue has room, with lock state and shift-register wait queue updated together.
// Reset: asynchronous, active low; clears the lock, holder, queue count and both buffers.
// Wait queue entries are not reset; only entries below the count are ever read.
// Top level: FIFO lock arbiter with admin preemption.
module fifo_lock_arbiter_with_preemption_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] requester_i,
  input  logic       is_admin_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [2:0] status_o,
  output logic       grant_valid_o,
  output logic [7:0] grant_id_o,
  output logic       holder_valid_o,
  output logic [7:0] holder_id_o,
  output logic [4:0] queue_length_o
);
  import lfa_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  res_t res_in, res_out;
  logic res_push, res_full;

  lfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .opcode_i    (opcode_i),
    .requester_i (requester_i),
    .is_admin_i  (is_admin_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  lfa_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  lfa_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .res_o      (res_out)
  );

  assign status_o       = res_out.status;
  assign grant_valid_o  = res_out.grant_valid;
  assign grant_id_o     = res_out.grant_id;
  assign holder_valid_o = res_out.holder_valid;
  assign holder_id_o    = res_out.holder_id;
  assign queue_length_o = res_out.queue_length;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the FIFO lock arbiter with admin preemption.
module tb;
  import lfa_pkg::*;

  localparam logic [1:0] OPC_NOP = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic       full_o;
  logic [1:0] opcode_i = OPC_REQUEST;
  logic [7:0] requester_i = 8'd0;
  logic       is_admin_i = 1'b0;
  logic       empty_o;
  logic       pop_i = 1'b0;
  logic [2:0] status_o;
  logic       grant_valid_o;
  logic [7:0] grant_id_o;
  logic       holder_valid_o;
  logic [7:0] holder_id_o;
  logic [4:0] queue_length_o;

  fifo_lock_arbiter_with_preemption_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .opcode_i      (opcode_i),
    .requester_i   (requester_i),
    .is_admin_i    (is_admin_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .status_o      (status_o),
    .grant_valid_o (grant_valid_o),
    .grant_id_o    (grant_id_o),
    .holder_valid_o(holder_valid_o),
    .holder_id_o   (holder_id_o),
    .queue_length_o(queue_length_o)
  );

  // Lock state as the testbench sees it.
  logic [7:0]  waiters[$];
  logic        lock_on = 1'b0;
  logic [7:0]  owner = 8'd0;
  res_t        pending_outcomes[$];

  int unsigned sender_idle_pct = 0;
  int unsigned reader_stall_pct = 0;
  int unsigned fail_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("FAIL");
    $finish;
  end

  function automatic logic is_waiting(logic [7:0] id);
    foreach (waiters[i]) begin
      if (waiters[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t arbitrate(logic [1:0] op, logic [7:0] id, logic admin);
    res_t res;
    logic bump;
    res = '0;
    res.status = ST_NOT_HOLDER;
    case (op)
      OPC_REQUEST: begin
        if (!lock_on) begin
          lock_on = 1'b1;
          owner = id;
          res.grant_valid = 1'b1;
          res.grant_id = id;
          res.status = ST_GRANTED;
        end else if (is_waiting(id)) begin
          res.status = ST_QUEUED;
        end else if (waiters.size() >= QUEUE_DEPTH) begin
          res.status = ST_QUEUE_FULL;
        end else begin
          waiters.push_back(id);
          res.status = ST_QUEUED;
        end
      end
      OPC_FORCE: begin
        if (!admin) begin
          res.status = ST_NOT_ADMIN;
        end else begin
          bump = lock_on && !is_waiting(owner);
          if (bump && waiters.size() >= QUEUE_DEPTH) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            // Put the displaced holder at the head of the line.
            if (bump) waiters.push_front(owner);
            lock_on = 1'b1;
            owner = id;
            res.grant_valid = 1'b1;
            res.grant_id = id;
            res.status = ST_OVERRIDE;
          end
        end
      end
      OPC_RELEASE: begin
        if (lock_on && owner == id) begin
          if (waiters.size() > 0) begin
            owner = waiters.pop_front();
            res.grant_valid = 1'b1;
            res.grant_id = owner;
          end else begin
            lock_on = 1'b0;
            owner = 8'd0;
          end
          res.status = ST_RELEASED;
        end
      end
      default: ;
    endcase
    res.holder_valid = lock_on;
    res.holder_id = lock_on ? owner : 8'd0;
    res.queue_length = 5'(waiters.size());
    return res;
  endfunction

  // Hold push high until the transaction is taken, then predict its outcome.
  task automatic send_cmd(logic [1:0] op, logic [7:0] id, logic admin);
    while ($urandom_range(99) < sender_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    opcode_i <= op;
    requester_i <= id;
    is_admin_i <= admin;
    do @(posedge clk_i); while (full_o);
    pending_outcomes.push_back(arbitrate(op, id, admin));
  endtask

  task automatic wait_results_done();
    int unsigned spin;
    push_i <= 1'b0;
    spin = 0;
    while (pending_outcomes.size() != 0 && spin < 20000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(99) >= reader_stall_pct);
  end

  always @(posedge clk_i) begin : check_outcome
    res_t got;
    res_t want;
    if (rst_ni && pop_i && !empty_o) begin
      got = {status_o, grant_valid_o, grant_id_o, holder_valid_o, holder_id_o,
             queue_length_o};
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transaction: st=%0d gv=%0b gid=%0d hv=%0b hid=%0d ql=%0d",
                   got.status, got.grant_valid, got.grant_id, got.holder_valid,
                   got.holder_id, got.queue_length);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status || got.grant_valid !== want.grant_valid ||
            got.grant_id !== want.grant_id || got.holder_valid !== want.holder_valid ||
            got.holder_id !== want.holder_id || got.queue_length !== want.queue_length) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch exp: st=%0d gv=%0b gid=%0d hv=%0b hid=%0d ql=%0d",
                     want.status, want.grant_valid, want.grant_id, want.holder_valid,
                     want.holder_id, want.queue_length);
            $display("         got: st=%0d gv=%0b gid=%0d hv=%0b hid=%0d ql=%0d",
                     got.status, got.grant_valid, got.grant_id, got.holder_valid,
                     got.holder_id, got.queue_length);
          end
        end
      end
    end
  end

  task automatic test_directed();
    sender_idle_pct = 7;
    reader_stall_pct = 54;
    send_cmd(OPC_RELEASE, 8'd5, 1'b0);      // release while free
    send_cmd(OPC_REQUEST, 8'd0, 1'b1);      // grant on free lock
    send_cmd(OPC_RELEASE, 8'd9, 1'b1);      // release by non-holder
    send_cmd(OPC_REQUEST, 8'd255, 1'b0);
    send_cmd(OPC_REQUEST, 8'd255, 1'b0);    // already waiting
    send_cmd(OPC_REQUEST, 8'd0, 1'b0);      // holder queues behind itself
    send_cmd(OPC_FORCE, 8'd7, 1'b0);        // non-admin takeover
    send_cmd(OPC_FORCE, 8'd200, 1'b1);      // holder already waiting
    send_cmd(OPC_FORCE, 8'd255, 1'b1);      // admin already waiting
    send_cmd(OPC_NOP, 8'd170, 1'b1);
    send_cmd(OPC_NOP, 8'd85, 1'b0);
    send_cmd(OPC_RELEASE, 8'd1, 1'b1);
    while (lock_on) send_cmd(OPC_RELEASE, owner, 1'($urandom_range(1)));
    send_cmd(OPC_FORCE, 8'd128, 1'b1);      // takeover of a free lock
    send_cmd(OPC_RELEASE, 8'd128, 1'b1);
    wait_results_done();
  endtask

  task automatic test_queue_full();
    logic [7:0] base;
    int k;
    base = 8'($urandom_range(238));
    while (lock_on) send_cmd(OPC_RELEASE, owner, 1'b0);
    send_cmd(OPC_REQUEST, base, 1'b0);
    for (k = 1; k <= QUEUE_DEPTH; k++)
      send_cmd(OPC_REQUEST, base + 8'(k), 1'($urandom_range(1)));
    send_cmd(OPC_REQUEST, base + 8'd17, 1'b0);  // saturated
    send_cmd(OPC_FORCE, base + 8'd17, 1'b1);    // holder cannot be queued
    send_cmd(OPC_FORCE, base + 8'd17, 1'b0);
    send_cmd(OPC_REQUEST, base + 8'd3, 1'b0);   // waiting client while full
    send_cmd(OPC_RELEASE, owner, 1'b0);
    send_cmd(OPC_FORCE, base + 8'd5, 1'b1);     // waiting admin takes over, refills
    send_cmd(OPC_FORCE, base + 8'd9, 1'b1);     // displaced holder already waiting
    while (lock_on) send_cmd(OPC_RELEASE, owner, 1'($urandom_range(1)));
    wait_results_done();
  endtask

  task automatic test_random(int unsigned count, int unsigned send_pct,
                             int unsigned stall_pct, int unsigned req_pct);
    logic [1:0] op;
    logic [7:0] id;
    logic [7:0] pool_base;
    logic admin;
    int unsigned pick;
    sender_idle_pct = send_pct;
    reader_stall_pct = stall_pct;
    pool_base = 8'($urandom_range(232));
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < req_pct) op = OPC_REQUEST;
      else if (pick < req_pct + 15) op = OPC_FORCE;
      else if (pick < 97) op = OPC_RELEASE;
      else op = OPC_NOP;
      // Draw mostly from a small pool so clients collide in the wait queue.
      if ($urandom_range(9) < 7) id = pool_base + 8'($urandom_range(23));
      else id = 8'($urandom_range(255));
      if (op == OPC_RELEASE && lock_on && $urandom_range(9) < 7) id = owner;
      admin = (op == OPC_FORCE) ? ($urandom_range(4) != 0) : 1'($urandom_range(1));
      send_cmd(op, id, admin);
    end
    wait_results_done();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_queue_full();
    test_random(615, 7, 54, 45);
    test_random(615, 54, 7, 52);
    test_random(615, 0, 0, 40);
    wait_results_done();
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
